@@ src/mhdg_pkg.sv @@
package mhdg_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLES_PER_HEADING_DEF = 3;
    localparam int CORDIC_STEPS_DEF        = 16;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 18;
    localparam int OFFSET_W    = 14;
    localparam int SUM_W       = 20;
    localparam int HEADING_W   = 15;
    localparam int FRAC_SHIFT  = 24;
    localparam int CORDIC_W    = 47;
    localparam int ANGLE_W     = 25;
    localparam int TURN_W      = 26;
    localparam int ATAN_LEN    = 24;
    localparam int STEP_W      = $clog2(ATAN_LEN);
    localparam int ROUND_SHIFT = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = CFG_INDEX_W'(1);

    localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = 14'sd640;
    localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = -14'sd1120;

    // Angles in units of 2^-16 degree.
    localparam logic signed [ANGLE_W-1:0] ANGLE_90  = 25'sd5898240;
    localparam logic signed [TURN_W-1:0]  ANGLE_180 = 26'sd11796480;
    localparam logic signed [TURN_W-1:0]  TURN_MAX  = 26'sd23592960;
    localparam logic signed [TURN_W-1:0]  ROUND_HALF = 26'sd512;

    localparam logic [HEADING_W-1:0] HEADING_ZERO_VEC = 15'd11520;
    localparam logic [HEADING_W-1:0] HEADING_MAX      = 15'd23040;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        sum_t sum_x;
        sum_t sum_y;
    } sum_pair_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ITER,
        BK_FINISH
    } back_state_t;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [ANGLE_W-1:0] val;
        begin
            unique case (idx)
                5'd0:    val = 25'sd2949120;
                5'd1:    val = 25'sd1740967;
                5'd2:    val = 25'sd919879;
                5'd3:    val = 25'sd466945;
                5'd4:    val = 25'sd234379;
                5'd5:    val = 25'sd117304;
                5'd6:    val = 25'sd58666;
                5'd7:    val = 25'sd29335;
                5'd8:    val = 25'sd14668;
                5'd9:    val = 25'sd7334;
                5'd10:   val = 25'sd3667;
                5'd11:   val = 25'sd1833;
                5'd12:   val = 25'sd917;
                5'd13:   val = 25'sd458;
                5'd14:   val = 25'sd229;
                5'd15:   val = 25'sd115;
                5'd16:   val = 25'sd57;
                5'd17:   val = 25'sd29;
                5'd18:   val = 25'sd14;
                5'd19:   val = 25'sd7;
                5'd20:   val = 25'sd4;
                5'd21:   val = 25'sd2;
                5'd22:   val = 25'sd1;
                default: val = 25'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

@@ src/mhdg_front.sv @@
module mhdg_front #(
    parameter int SAMPLES_PER_HEADING = mhdg_pkg::SAMPLES_PER_HEADING_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [mhdg_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic signed [mhdg_pkg::OFFSET_W-1:0]    cfg_data,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [mhdg_pkg::SAMPLE_W-1:0]    mag_x,
    input  logic signed [mhdg_pkg::SAMPLE_W-1:0]    mag_y,
    output logic                                    q_push,
    output mhdg_pkg::sum_pair_t                     q_data,
    input  logic                                    q_full
);
    import mhdg_pkg::*;

    localparam int CNT_W = (SAMPLES_PER_HEADING > 1) ? $clog2(SAMPLES_PER_HEADING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_HEADING - 1);

    logic signed [OFFSET_W-1:0] offset_x_reg;
    logic signed [OFFSET_W-1:0] offset_y_reg;
    sum_t                       sum_x_reg;
    sum_t                       sum_y_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic                       last_sample;
    logic                       accept;
    logic signed [SAMPLE_W:0]   vx;
    logic signed [SAMPLE_W:0]   vy;
    logic signed [SUM_W:0]      wide_x;
    logic signed [SUM_W:0]      wide_y;
    sum_t                       sat_x;
    sum_t                       sat_y;

    // Only the beat that completes a heading needs room in the queue.
    assign last_sample = (cnt_reg == CNT_LAST);
    assign full        = q_full & last_sample;
    assign accept      = push & ~full;

    always_comb
    begin
        vx     = (SAMPLE_W + 1)'(mag_x) + (SAMPLE_W + 1)'(offset_x_reg);
        vy     = (SAMPLE_W + 1)'(mag_y) + (SAMPLE_W + 1)'(offset_y_reg);
        wide_x = (SUM_W + 1)'(sum_x_reg) + (SUM_W + 1)'(vx);
        wide_y = (SUM_W + 1)'(sum_y_reg) + (SUM_W + 1)'(vy);
        // The top two bits disagree exactly when the sum left the 20-bit range.
        if (wide_x[SUM_W] != wide_x[SUM_W-1])
        begin
            sat_x = wide_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sat_x = wide_x[SUM_W-1:0];
        end
        if (wide_y[SUM_W] != wide_y[SUM_W-1])
        begin
            sat_y = wide_y[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sat_y = wide_y[SUM_W-1:0];
        end
    end

    assign q_push       = accept & last_sample;
    assign q_data.sum_x = sat_x;
    assign q_data.sum_y = sat_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RST;
            offset_y_reg <= OFFSET_Y_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_OFFSET_X)
            begin
                offset_x_reg <= cfg_data;
            end
            if (cfg_index == REG_OFFSET_Y)
            begin
                offset_y_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                sum_x_reg <= sat_x;
                sum_y_reg <= sat_y;
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("sample counter passed the heading boundary");
`endif

endmodule

@@ src/mhdg_queue.sv @@
module mhdg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mhdg_pkg::sum_pair_t data_in,
    output logic                full,
    input  logic                pop,
    output mhdg_pkg::sum_pair_t data_out,
    output logic                empty
);
    import mhdg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sum_pair_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("front pushed a sum pair into a full queue");
`endif

endmodule

@@ src/mhdg_back.sv @@
module mhdg_back #(
    parameter int CORDIC_STEPS = mhdg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  mhdg_pkg::sum_pair_t              q_data,
    output logic                             q_pop,
    output logic                             empty,
    input  logic                             pop,
    output logic [mhdg_pkg::HEADING_W-1:0]   heading
);
    import mhdg_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic [STEP_W-1:0]           step_reg;
    logic signed [CORDIC_W-1:0]  a_reg;
    logic signed [CORDIC_W-1:0]  b_reg;
    logic signed [ANGLE_W-1:0]   z_reg;
    logic                        zero_reg;
    logic                        out_valid_reg;
    logic [HEADING_W-1:0]        heading_reg;

    logic signed [SUM_W:0]       sx_ld;
    logic signed [SUM_W:0]       sy_ld;
    logic signed [SUM_W:0]       a_sel;
    logic signed [SUM_W:0]       b_sel;
    logic signed [CORDIC_W-1:0]  a_load;
    logic signed [CORDIC_W-1:0]  b_load;
    logic signed [ANGLE_W-1:0]   z_load;
    logic signed [CORDIC_W-1:0]  da;
    logic signed [CORDIC_W-1:0]  db;
    logic signed [ANGLE_W-1:0]   atan_val;
    logic signed [CORDIC_W-1:0]  a_next;
    logic signed [CORDIC_W-1:0]  b_next;
    logic signed [ANGLE_W-1:0]   z_next;
    logic signed [TURN_W-1:0]    turn;
    logic signed [TURN_W-1:0]    turn_cl;
    logic signed [TURN_W-1:0]    turn_rnd;
    logic [HEADING_W-1:0]        heading_next;
    logic                        slot_free;
    logic                        finish_write;

    // Load: a negative sum_y is pre-rotated by +/-90 degrees so that the vector sits in the right half plane.
    always_comb
    begin
        sx_ld = (SUM_W + 1)'(q_data.sum_x);
        sy_ld = (SUM_W + 1)'(q_data.sum_y);
        if (!sy_ld[SUM_W])
        begin
            a_sel  = sy_ld;
            b_sel  = sx_ld;
            z_load = '0;
        end
        else if (!sx_ld[SUM_W])
        begin
            a_sel  = sx_ld;
            b_sel  = -sy_ld;
            z_load = ANGLE_90;
        end
        else
        begin
            a_sel  = -sx_ld;
            b_sel  = sy_ld;
            z_load = -ANGLE_90;
        end
        a_load = CORDIC_W'(a_sel) <<< FRAC_SHIFT;
        b_load = CORDIC_W'(b_sel) <<< FRAC_SHIFT;
    end

    // One vectoring step; arithmetic right shift is the floor shift.
    always_comb
    begin
        da       = b_reg >>> step_reg;
        db       = a_reg >>> step_reg;
        atan_val = atan_entry(step_reg);
        if (!b_reg[CORDIC_W-1])
        begin
            a_next = a_reg + da;
            b_next = b_reg - db;
            z_next = z_reg + atan_val;
        end
        else
        begin
            a_next = a_reg - da;
            b_next = b_reg + db;
            z_next = z_reg - atan_val;
        end
    end

    // Offset to 0..360 degrees, clamp, round to 1/64 degree; a zero vector gives 180 degrees.
    always_comb
    begin
        turn = TURN_W'(z_reg) + ANGLE_180;
        if (turn[TURN_W-1])
        begin
            turn_cl = '0;
        end
        else if (turn > TURN_MAX)
        begin
            turn_cl = TURN_MAX;
        end
        else
        begin
            turn_cl = turn;
        end
        turn_rnd     = (turn_cl + ROUND_HALF) >>> ROUND_SHIFT;
        heading_next = zero_reg ? HEADING_ZERO_VEC : turn_rnd[HEADING_W-1:0];
    end

    assign slot_free = ~out_valid_reg | pop;

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        finish_write = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_ITER;
                end
            end
            BK_ITER:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (slot_free)
                begin
                    finish_write = 1'b1;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                step_reg <= '0;
            end
            else if (state_reg == BK_ITER)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (finish_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_reg    <= a_load;
            b_reg    <= b_load;
            z_reg    <= z_load;
            zero_reg <= (q_data.sum_x == '0) && (q_data.sum_y == '0);
        end
        else if (state_reg == BK_ITER)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            z_reg <= z_next;
        end
        if (finish_write)
        begin
            heading_reg <= heading_next;
        end
    end

    assign empty   = ~out_valid_reg;
    assign heading = heading_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ITER) |-> (step_reg <= STEP_LAST))
        else $error("CORDIC step counter ran past the last step");
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (heading_reg <= HEADING_MAX))
        else $error("heading above 360 degrees");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_FINISH))
        else $error("result appeared without a finished CORDIC run");
`endif

endmodule

@@ src/magnetometer_heading_unit.sv @@
// Magnetometer compass heading.
// Input channel: push with mag_x/mag_y; a beat is taken when push is high and full low.
// Each sample has the hard-iron offsets added and is summed (saturating at 20 bits).
// Every SAMPLES_PER_HEADING-th beat closes a group and hands the sum pair to a
// two-entry queue; the heading engine then runs an iterative CORDIC in vectoring
// mode and yields heading = atan2(sum_x, sum_y) + 180 degrees in 1/64 degree.
// Result channel: heading is valid while empty is low and is taken when pop is high.
// The heading engine handles each group in order: it loads the sum pair from the queue,
// runs CORDIC_STEPS iterations (16 by default) of the shared add/subtract pair, and
// rounds the angle into the result register. Samples keep being taken while the engine
// works on a heading; bursts of samples are taken every cycle while the queue has room.
// full rises only on the group-closing beat, when the queue holds two pending groups.
// If pop stays low the result register holds, the engine waits in its rounding cycle,
// the queue fills and then full stops the input.
// Offsets are written through cfg_write/cfg_index/cfg_data (0: offset_x, 1: offset_y);
// the user must write them only while the block is idle, as the block does not enforce it.
// Reset clears sums, counter, queue and result, and loads the offsets with 640 and -1120.
module magnetometer_heading_unit #(
    parameter int SAMPLES_PER_HEADING = mhdg_pkg::SAMPLES_PER_HEADING_DEF,
    parameter int CORDIC_STEPS        = mhdg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mhdg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic signed [mhdg_pkg::OFFSET_W-1:0]  cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [mhdg_pkg::SAMPLE_W-1:0]  mag_x,
    input  logic signed [mhdg_pkg::SAMPLE_W-1:0]  mag_y,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [mhdg_pkg::HEADING_W-1:0]        heading
);
    import mhdg_pkg::*;

    // Sum pairs travel from the accumulator to the heading engine through this queue.
    logic       q_push;
    sum_pair_t  q_in;
    logic       q_full;
    logic       q_pop;
    sum_pair_t  q_out;
    logic       q_empty;

    mhdg_front #(
        .SAMPLES_PER_HEADING (SAMPLES_PER_HEADING)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    mhdg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out),
        .empty    (q_empty)
    );

    // The engine pops one sum pair, iterates, and parks its answer in the result register.
    mhdg_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .heading (heading)
    );

endmodule
